// File: rtl/askf_pkg.sv
// ----------------------------------------------------------------------------
// askf_pkg - shared types and constants
// Widths, reset values, register codes and sequencer states of the adaptive
// scalar Kalman filter unit.
// ----------------------------------------------------------------------------
`default_nettype none

package askf_pkg;

  localparam int unsigned WINDOW_LENGTH_DEF = 50;

  // divider operand widths: gain numerator is P << 16, denominator P + R
  localparam int unsigned DIV_NUM_W = 48;
  localparam int unsigned DIV_DEN_W = 33;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [16:0] ONE_Q16       = 17'h10000;
  localparam logic [60:0] TERM_SAT      = 61'h1000_0000_0000_0000;

  localparam logic [31:0] EST_RESET     = 32'd642253;
  localparam logic [31:0] COV_RESET     = 32'd65536;
  localparam logic [30:0] NOISE_RESET   = 31'd65536;

  localparam logic [16:0] PN_RESET      = 17'd655;
  localparam logic [31:0] CSQ_RESET     = 32'hFFFF_FE50;  // -432
  localparam logic [31:0] CLIN_RESET    = 32'd27168;
  localparam logic [31:0] COFF_RESET    = 32'd67628;
  localparam logic [16:0] SW_RESET      = 17'd6554;
  localparam logic [30:0] RMIN_RESET    = 31'd6554;
  localparam logic [30:0] RMAX_RESET    = 31'd655360;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROCESS_NOISE    = 3'd0,
    CFG_COEF_SQUARE      = 3'd1,
    CFG_COEF_LINEAR      = 3'd2,
    CFG_COEF_OFFSET      = 3'd3,
    CFG_SMOOTHING_WEIGHT = 3'd4,
    CFG_R_MIN            = 3'd5,
    CFG_R_MAX            = 3'd6
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ,
    ST_WIN,
    ST_MEAN,
    ST_MEAN_HI,
    ST_MEAN_FIX,
    ST_M2,
    ST_T2_HI,
    ST_T2_LO,
    ST_T1,
    ST_CLAMP,
    ST_SM_NEW,
    ST_SM_OLD,
    ST_GAIN,
    ST_GAIN_WAIT,
    ST_EST,
    ST_COV,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// File: rtl/askf_div.sv
// ----------------------------------------------------------------------------
// askf_div - restoring divider
// Unsigned quotient of a 48-bit numerator by a 33-bit divisor, one quotient
// bit per cycle. Divisor must be nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module askf_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [askf_pkg::DIV_NUM_W-1:0] num,
  input  wire logic [askf_pkg::DIV_DEN_W-1:0] den,
  output logic                                busy,
  output logic                                done,
  output logic      [askf_pkg::DIV_NUM_W-1:0] quot
);
  import askf_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_DEN_W:0]   rem;
  logic [DIV_DEN_W-1:0] divisor;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W+1:0] diff;

  assign shifted = {rem[DIV_DEN_W-1:0], quot[DIV_NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      quot    <= num;
      divisor <= den;
      cnt     <= CNT_W'(DIV_NUM_W);
    end else if (busy) begin
      // keep the trial difference when it does not go negative
      rem  <= diff[DIV_DEN_W+1] ? shifted : diff[DIV_DEN_W:0];
      quot <= {quot[DIV_NUM_W-2:0], ~diff[DIV_DEN_W+1]};
      cnt  <= cnt - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: rtl/adaptive_scalar_kalman_filter_unit.sv
// ----------------------------------------------------------------------------
// adaptive_scalar_kalman_filter_unit - scalar Kalman filter, adaptive R
// One-dimensional Kalman filter whose measurement noise follows the variance
// of the innovation over a sliding window.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel : sample_valid / sample_ready, sample_value (Q16.16 signed).
//   result channel : result_valid / result_ready, filtered_estimate and
//                    noise_estimate (smoothed R, Q16.16).
//   config channel : cfg_valid / cfg_ready / cfg_index / cfg_data; always
//                    ready, write only while no request is in flight.
//   One request at a time: a new request is taken only once the sequencer
//   is back in idle. One 32x32 multiplier is shared over twelve steps, the
//   window mean uses a reciprocal multiply with a small fix-up, and the gain
//   comes from the radix-2 divider, which is skipped when P + R is zero.
//   sample_ready is high only while the sequencer is idle; a new request may
//   enter while the previous result still waits in the output register.
//   If the receiver stalls, the finished request waits in the done step
//   until the output register frees up.
//   Reset (rst, synchronous) restores the filter state and register defaults
//   and marks every window entry empty at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_scalar_kalman_filter_unit #(
  parameter int unsigned WINDOW_LENGTH = askf_pkg::WINDOW_LENGTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           sample_valid,
  output logic                                sample_ready,
  input  wire logic signed [31:0]             sample_value,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output logic signed [31:0]                  filtered_estimate,
  output logic        [30:0]                  noise_estimate,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [askf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [askf_pkg::CFG_DAT_W-1:0] cfg_data
);
  import askf_pkg::*;

  localparam int unsigned POS_W = $clog2(WINDOW_LENGTH);
  localparam int unsigned SUM_W = 32 + $clog2(WINDOW_LENGTH);

  // reciprocal of the window length; the truncated quotient is at most two
  // below the true mean and is fixed up by compare against the remainder
  localparam int unsigned RECIP_SHIFT = 31 + $clog2(WINDOW_LENGTH);
  localparam logic [63:0] RECIP_FULL  = (64'd1 << RECIP_SHIFT) / 64'(WINDOW_LENGTH);
  localparam logic [31:0] RECIP       = RECIP_FULL[31:0];

  // configuration registers
  logic [16:0] process_noise;
  logic [31:0] coef_square;
  logic [31:0] coef_linear;
  logic [31:0] coef_offset;
  logic [16:0] smoothing_weight;
  logic [30:0] r_min;
  logic [30:0] r_max;

  // filter state
  logic [31:0] estimate;
  logic [31:0] error_covariance;
  logic [30:0] smoothed_noise;
  logic [POS_W-1:0] window_pos;
  logic [SUM_W-1:0] window_sum;

  // window store
  logic [31:0]              win_mem [WINDOW_LENGTH];
  logic [31:0]              win_rd;
  logic [WINDOW_LENGTH-1:0] win_vld;
  logic                     win_we;
  logic [31:0]              win_old;

  // per-request work registers
  state_t state, state_next;
  logic [31:0] p_cur;
  logic [31:0] innov_mag;
  logic        innov_neg;
  logic [31:0] sq;
  logic [31:0] mean;
  logic [47:0] mean_sq;
  logic [63:0] acc;
  logic signed [63:0] raw;
  logic [30:0] r_clamped;
  logic [16:0] gain;
  logic [16:0] weight;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  // divider
  logic div_start;
  logic div_busy;
  logic div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quot;
  logic [DIV_DEN_W-1:0] div_den;

  // combinational helpers
  logic [32:0] p_sum;
  logic signed [32:0] innov;
  logic [72:0] mean_t;
  logic [SUM_W-1:0] mean_rem;
  logic [64:0] t2_sum;
  logic [60:0] t2;
  logic [31:0] cs_mag, cl_mag;
  logic [48:0] smooth_sum;
  logic [32:0] denom;
  logic [32:0] est_next;
  logic [31:0] delta;

  assign cfg_ready    = 1'b1;
  assign sample_ready = (state == ST_IDLE);

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise    <= PN_RESET;
      coef_square      <= CSQ_RESET;
      coef_linear      <= CLIN_RESET;
      coef_offset      <= COFF_RESET;
      smoothing_weight <= SW_RESET;
      r_min            <= RMIN_RESET;
      r_max            <= RMAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PROCESS_NOISE:    process_noise    <= cfg_data[16:0];
        CFG_COEF_SQUARE:      coef_square      <= cfg_data;
        CFG_COEF_LINEAR:      coef_linear      <= cfg_data;
        CFG_COEF_OFFSET:      coef_offset      <= cfg_data;
        CFG_SMOOTHING_WEIGHT: smoothing_weight <= cfg_data[16:0];
        CFG_R_MIN:            r_min            <= cfg_data[30:0];
        CFG_R_MAX:            r_max            <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // ----------------------------------------------------------- window store
  // Read data is registered every cycle at window_pos; an entry never
  // written since reset reads as zero through its valid bit.
  assign win_we  = (state == ST_WIN);
  assign win_old = win_vld[window_pos] ? win_rd : 32'd0;

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[window_pos] <= sq;
    end
    win_rd <= win_mem[window_pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_vld <= '0;
    end else if (win_we) begin
      win_vld[window_pos] <= 1'b1;
    end
  end

  // ------------------------------------------------------------ arithmetic
  assign p_sum  = {1'b0, error_covariance} + {16'd0, process_noise};
  assign innov  = {sample_value[31], sample_value} - {estimate[31], estimate};
  assign cs_mag = coef_square[31] ? (32'd0 - coef_square) : coef_square;
  assign cl_mag = coef_linear[31] ? (32'd0 - coef_linear) : coef_linear;
  assign prod   = 64'(mul_a) * 64'(mul_b);

  // window mean: sum times reciprocal, high part plus low part
  assign mean_t   = {prod[40:0], 32'd0} + {9'd0, acc};
  assign mean_rem = window_sum - prod[SUM_W-1:0];

  // quadratic term: high partial product plus low partial product, capped
  assign t2_sum = {1'b0, acc} + {17'd0, prod[63:16]};
  assign t2     = (t2_sum > 65'(TERM_SAT)) ? TERM_SAT : t2_sum[60:0];

  assign smooth_sum = {1'b0, acc[47:0]} + {1'b0, prod[47:0]};
  assign denom      = {1'b0, p_cur} + {2'b00, smoothed_noise};
  assign delta      = prod[47:16];
  assign est_next   = innov_neg ? ({estimate[31], estimate} - {1'b0, delta})
                                : ({estimate[31], estimate} + {1'b0, delta});

  // -------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (sample_valid) state_next = ST_SQ;
      ST_SQ:        state_next = ST_WIN;
      ST_WIN:       state_next = ST_MEAN;
      ST_MEAN:      state_next = ST_MEAN_HI;
      ST_MEAN_HI:   state_next = ST_MEAN_FIX;
      ST_MEAN_FIX:  state_next = ST_M2;
      ST_M2:        state_next = ST_T2_HI;
      ST_T2_HI:     state_next = ST_T2_LO;
      ST_T2_LO:     state_next = ST_T1;
      ST_T1:        state_next = ST_CLAMP;
      ST_CLAMP:     state_next = ST_SM_NEW;
      ST_SM_NEW:    state_next = ST_SM_OLD;
      ST_SM_OLD:    state_next = ST_GAIN;
      ST_GAIN:      state_next = (denom == 33'd0) ? ST_EST : ST_GAIN_WAIT;
      ST_GAIN_WAIT: if (div_done) state_next = ST_EST;
      ST_EST:       state_next = ST_COV;
      ST_COV:       state_next = ST_DONE;
      ST_DONE:      if (!result_valid || result_ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ------------------------------------------- multiplier and divider steer
  always_comb begin
    mul_a     = 32'd0;
    mul_b     = 32'd0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      ST_SQ: begin
        mul_a = innov_mag;
        mul_b = innov_mag;
      end
      ST_MEAN: begin
        mul_a = window_sum[31:0];
        mul_b = RECIP;
      end
      ST_MEAN_HI: begin
        mul_a = 32'(window_sum >> 32);
        mul_b = RECIP;
      end
      ST_MEAN_FIX: begin
        mul_a = mean;
        mul_b = 32'(WINDOW_LENGTH);
      end
      ST_M2: begin
        mul_a = mean;
        mul_b = mean;
      end
      ST_T2_HI: begin
        mul_a = mean_sq[47:16];
        mul_b = cs_mag;
      end
      ST_T2_LO: begin
        mul_a = {16'd0, mean_sq[15:0]};
        mul_b = cs_mag;
      end
      ST_T1: begin
        mul_a = mean;
        mul_b = cl_mag;
      end
      ST_SM_NEW: begin
        mul_a = {15'd0, weight};
        mul_b = {1'b0, r_clamped};
      end
      ST_SM_OLD: begin
        mul_a = {15'd0, ONE_Q16 - weight};
        mul_b = {1'b0, smoothed_noise};
      end
      ST_GAIN: begin
        div_start = (denom != 33'd0);
        div_num   = {p_cur, 16'd0};
        div_den   = denom;
      end
      ST_EST: begin
        mul_a = {15'd0, gain};
        mul_b = innov_mag;
      end
      ST_COV: begin
        mul_a = {15'd0, ONE_Q16 - gain};
        mul_b = p_cur;
      end
      default: ;
    endcase
  end

  askf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // ---------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        // latch grown covariance (saturated), innovation sign and magnitude, weight capped at one
        p_cur     <= p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
        innov_neg <= innov[32];
        innov_mag <= innov[32] ? 32'(-innov) : innov[31:0];
        weight    <= (smoothing_weight > ONE_Q16) ? ONE_Q16 : smoothing_weight;
      end
      ST_SQ:        sq <= (prod[63:48] != 16'd0) ? 32'hFFFF_FFFF : prod[47:16];
      ST_MEAN:      acc <= prod;
      ST_MEAN_HI:   mean <= mean_t[RECIP_SHIFT +: 32];
      ST_MEAN_FIX: begin
        // advance the estimated quotient by what the remainder still holds
        if (mean_rem >= SUM_W'(2 * WINDOW_LENGTH)) begin
          mean <= mean + 32'd2;
        end else if (mean_rem >= SUM_W'(WINDOW_LENGTH)) begin
          mean <= mean + 32'd1;
        end
      end
      ST_M2:        mean_sq <= prod[63:16];
      ST_T2_HI:     acc <= prod;
      ST_T2_LO: begin
        raw <= (coef_square[31] ? -$signed({3'b000, t2}) : $signed({3'b000, t2}))
             + 64'(signed'(coef_offset));
      end
      ST_T1: begin
        raw <= coef_linear[31] ? raw - $signed({16'd0, prod[63:16]})
                               : raw + $signed({16'd0, prod[63:16]});
      end
      ST_CLAMP: begin
        // lower clamp wins over upper clamp
        if (raw < $signed({33'd0, r_min})) begin
          r_clamped <= r_min;
        end else if (raw > $signed({33'd0, r_max})) begin
          r_clamped <= r_max;
        end else begin
          r_clamped <= raw[30:0];
        end
      end
      ST_SM_NEW:    acc <= prod;
      ST_GAIN:      gain <= 17'd0;
      ST_GAIN_WAIT: gain <= (div_quot > DIV_NUM_W'(ONE_Q16)) ? ONE_Q16 : div_quot[16:0];
      default: ;
    endcase
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      estimate         <= EST_RESET;
      error_covariance <= COV_RESET;
      smoothed_noise   <= NOISE_RESET;
      window_pos       <= '0;
      window_sum       <= '0;
    end else begin
      case (state)
        ST_WIN: begin
          window_sum <= window_sum - SUM_W'(win_old) + SUM_W'(sq);
          window_pos <= (window_pos == POS_W'(WINDOW_LENGTH - 1))
                        ? '0 : window_pos + POS_W'(1);
        end
        ST_SM_OLD: smoothed_noise <= smooth_sum[46:16];
        ST_EST:    estimate <= est_next[31:0];
        ST_COV:    error_covariance <= prod[47:16];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_DONE && (!result_valid || result_ready)) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!result_valid || result_ready)) begin
      filtered_estimate <= estimate;
      noise_estimate    <= smoothed_noise;
    end
  end

  // ------------------------------------------------------------ assertions
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=> (state == ST_SQ))
    else $error("accepted request did not start the sequence");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !div_busy)
    else $error("divider busy while sequencer idle");

  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EST) |-> (gain <= ONE_Q16))
    else $error("gain above one");

  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && result_valid && !result_ready) |=> (state == ST_DONE))
    else $error("result dropped while receiver stalled");

endmodule

`default_nettype wire

// File: verif/tb_adaptive_scalar_kalman_filter_unit.sv
// ----------------------------------------------------------------------------
// tb_adaptive_scalar_kalman_filter_unit - self-checking bench of the filter
// Drives samples and register writes, predicts every filter step in a
// scoreboard and compares both result fields in order under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_adaptive_scalar_kalman_filter_unit;
  import askf_pkg::*;

  localparam int unsigned WIN = WINDOW_LENGTH_DEF;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [31:0] est;
    logic [30:0]        noise;
  } kf_result_t;

  // Scoreboard: holds its own filter state and register copies, predicts the
  // result of each accepted request and checks results in arrival order.
  class kf_scoreboard;
    logic [16:0] pn, sw;
    logic [31:0] csq, clin, coff;
    logic [30:0] rmin, rmax;
    logic signed [31:0] est;
    logic [31:0] cov;
    logic [30:0] noise;
    logic [31:0] ring [WIN];
    int unsigned pos;
    logic [63:0] ring_sum;
    kf_result_t pending [$];
    int errors;

    function void reset_state();
      pn = PN_RESET; csq = CSQ_RESET; clin = CLIN_RESET; coff = COFF_RESET;
      sw = SW_RESET; rmin = RMIN_RESET; rmax = RMAX_RESET;
      est = EST_RESET; cov = COV_RESET; noise = NOISE_RESET;
      foreach (ring[i]) ring[i] = '0;
      pos = 0; ring_sum = '0; errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] d);
      case (idx)
        CFG_PROCESS_NOISE:    pn = d[16:0];
        CFG_COEF_SQUARE:      csq = d;
        CFG_COEF_LINEAR:      clin = d;
        CFG_COEF_OFFSET:      coff = d;
        CFG_SMOOTHING_WEIGHT: sw = d[16:0];
        CFG_R_MIN:            rmin = d[30:0];
        CFG_R_MAX:            rmax = d[30:0];
        default: ;
      endcase
    endfunction

    // (c*v)>>16 with magnitude saturated at 2^60, sign of c applied
    function longint poly_term(logic [31:0] c, logic [63:0] v);
      logic [63:0] m, hi, lo;
      m = c[31] ? 64'(-$signed({32'hFFFF_FFFF, c})) : {32'd0, c};
      hi = (v >> 16) * m;
      lo = ((v & 64'hFFFF) * m) >> 16;
      if (hi > 64'(TERM_SAT)) hi = 64'(TERM_SAT);
      else begin
        hi = hi + lo;
        if (hi > 64'(TERM_SAT)) hi = 64'(TERM_SAT);
      end
      return c[31] ? -longint'(hi) : longint'(hi);
    endfunction

    function void note_sample(logic signed [31:0] z);
      logic [63:0] p, sq, mag, mean, w, rc, r, den, k, dl;
      longint innov, raw, e;
      kf_result_t res;
      p = 64'(cov) + 64'(pn);
      if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
      innov = longint'(z) - longint'(est);
      mag = innov < 0 ? 64'(-innov) : 64'(innov);
      sq = (mag * mag) >> 16;
      if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
      ring_sum = ring_sum - ring[pos] + sq;
      ring[pos] = sq[31:0];
      pos = (pos + 1) % WIN;
      mean = ring_sum / WIN;
      raw = poly_term(csq, (mean * mean) >> 16) + poly_term(clin, mean)
          + longint'($signed(coff));
      if (raw < longint'(rmin)) rc = 64'(rmin);
      else if (raw > longint'(rmax)) rc = 64'(rmax);
      else rc = 64'(raw);
      w = sw > ONE_Q16 ? 64'(ONE_Q16) : 64'(sw);
      r = (w * rc + (64'(ONE_Q16) - w) * 64'(noise)) >> 16;
      noise = r[30:0];
      den = p + 64'(noise);
      k = den == 0 ? 64'd0 : (p << 16) / den;
      if (k > 64'(ONE_Q16)) k = 64'(ONE_Q16);
      dl = (k * mag) >> 16;
      e = innov < 0 ? longint'(est) - longint'(dl) : longint'(est) + longint'(dl);
      est = e[31:0];
      cov = 32'(((64'(ONE_Q16) - k) * p) >> 16);
      res.est = est;
      res.noise = noise;
      pending.push_back(res);
    endfunction

    function void check_result(logic signed [31:0] e, logic [30:0] n);
      kf_result_t x;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result est=%0d noise=%0d", e, n);
        return;
      end
      x = pending.pop_front();
      if (x.est !== e || x.noise !== n) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: est exp %0d got %0d, noise exp %0d got %0d",
                   x.est, e, x.noise, n);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  logic signed [31:0] sample_value = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic signed [31:0] filtered_estimate;
  logic [30:0] noise_estimate;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  kf_scoreboard sb;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  bit sink_hold = 1'b0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  adaptive_scalar_kalman_filter_unit i_dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_ready(sample_ready),
    .sample_value(sample_value),
    .result_valid(result_valid), .result_ready(result_ready),
    .filtered_estimate(filtered_estimate), .noise_estimate(noise_estimate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Sample handshakes at the rising edge: note requests, check results, count idle cycles.
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && sample_ready) sb.note_sample(sample_value);
      if (result_valid && result_ready)
        sb.check_result(filtered_estimate, noise_estimate);
      if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog: a long run of cycles without any handshake ends the run.
  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_adaptive_scalar_kalman_filter_unit failed");
      $finish;
    end
  end

  // Receiver: random back-pressure, or a long hold-off when asked.
  always @(negedge clk) begin
    if (sink_hold) result_ready <= 1'b0;
    else result_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Offer one sample; hold it until accepted, then drop valid and idle for a
  // random while.
  task automatic send_sample(logic signed [31:0] z);
    sample_value <= z;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    @(negedge clk);
    sample_valid <= 1'b0;
    do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
  endtask

  // Drain outstanding results, then let the sequencer settle.
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Random sample: mostly near the running estimate, sometimes anywhere.
  function automatic logic signed [31:0] pick_sample();
    int sel;
    sel = $urandom_range(9);
    if (sel < 6) return sb.est + $signed(32'($urandom_range(400000)) - 32'd200000);
    if (sel < 8) return sb.est + $signed(32'($urandom_range(20000000)) - 32'd10000000);
    return $urandom;
  endfunction

  task automatic random_regs();
    write_reg(CFG_PROCESS_NOISE, $urandom_range(65536));
    write_reg(CFG_COEF_SQUARE, ($urandom_range(3) == 0) ? $urandom
                               : 32'($signed(32'($urandom_range(2000))) - 1000));
    write_reg(CFG_COEF_LINEAR, ($urandom_range(3) == 0) ? $urandom
                               : 32'($urandom_range(100000)));
    write_reg(CFG_COEF_OFFSET, ($urandom_range(3) == 0) ? $urandom
                               : 32'($urandom_range(200000)));
    write_reg(CFG_SMOOTHING_WEIGHT, $urandom_range(131071));
    write_reg(CFG_R_MIN, $urandom_range(3) == 0 ? {1'b0, 31'($urandom)}
                                                : 32'($urandom_range(1, 20000)));
    write_reg(CFG_R_MAX, $urandom_range(3) == 0 ? {1'b0, 31'($urandom)}
                                                : 32'($urandom_range(1, 2000000)));
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes and big innovations
    src_idle_pct = 15; sink_idle_pct = 45;
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sd0);
    send_sample(-32'sd1);
    send_sample(32'sd642253);
    send_sample(32'sh5555_5555);
    send_sample(32'shAAAA_AAAA);
    drain();

    // register extremes: zero process noise, zero weight, weight above one,
    // inverted clamps, saturating coefficients
    write_reg(CFG_PROCESS_NOISE, 32'd0);
    write_reg(CFG_SMOOTHING_WEIGHT, 32'd131071);
    write_reg(CFG_R_MIN, 32'd1);
    write_reg(CFG_R_MAX, 32'd1);
    write_reg(CFG_COEF_SQUARE, 32'h7FFF_FFFF);
    write_reg(CFG_COEF_LINEAR, 32'h8000_0000);
    write_reg(CFG_COEF_OFFSET, 32'h8000_0000);
    repeat (4) send_sample($urandom);
    send_sample(32'sh7FFF_FFFF);
    drain();
    write_reg(CFG_PROCESS_NOISE, 32'd65536);
    write_reg(CFG_SMOOTHING_WEIGHT, 32'd0);
    write_reg(CFG_R_MIN, 32'h7FFF_FFFF);
    write_reg(CFG_R_MAX, 32'd5);
    write_reg(CFG_COEF_SQUARE, 32'h8000_0000);
    write_reg(CFG_COEF_LINEAR, 32'h7FFF_FFFF);
    write_reg(CFG_COEF_OFFSET, 32'h7FFF_FFFF);
    repeat (4) send_sample($urandom);
    drain();
    write_reg(CFG_SMOOTHING_WEIGHT, 32'd65536);
    write_reg(CFG_R_MIN, 32'd6554);
    write_reg(CFG_R_MAX, 32'd655360);
    write_reg(CFG_COEF_SQUARE, CSQ_RESET);
    write_reg(CFG_COEF_LINEAR, CLIN_RESET);
    write_reg(CFG_COEF_OFFSET, COFF_RESET);

    // random phases: new register setting between phases, idling profile
    // moves from sender-light to receiver-light to none
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin src_idle_pct = 45; sink_idle_pct = 15; end
      if (ph == 4) begin src_idle_pct = 0; sink_idle_pct = 0; end
      for (int n = 0; n < 270; n++) begin
        // long receiver hold-off while the sender keeps offering
        if (ph == 1 && n == 20) begin
          fork
            begin
              sink_hold = 1'b1;
              repeat (2000) @(negedge clk);
              sink_hold = 1'b0;
            end
          join_none
        end
        send_sample(pick_sample());
      end
      drain();
      if (ph != 5) random_regs();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_adaptive_scalar_kalman_filter_unit passed");
    else
      $display("tb_adaptive_scalar_kalman_filter_unit failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/askf_pkg.sv
rtl/askf_div.sv
rtl/adaptive_scalar_kalman_filter_unit.sv
verif/tb_adaptive_scalar_kalman_filter_unit.sv
